// ===== rtl/core/touch_sample_filter_queue_defines.svh =====
// Assertion macros used by the checker file of the touch sample queue.
`ifndef TOUCH_SAMPLE_FILTER_QUEUE_DEFINES_SVH
`define TOUCH_SAMPLE_FILTER_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSFQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSFQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tsfq_pkg.sv =====
`timescale 1ns / 1ps
package tsfq_pkg;

  localparam int RING_DEPTH = 16;
  localparam int IDX_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  localparam int COORD_W = 16;
  localparam int TIME_W  = 63;
  localparam int GEN_W   = 32;
  localparam int GAP_W   = 32;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 136;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [GAP_W-1:0] MAX_GAP_RESET = 32'd100000;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_INTERRUPT_DRIVEN = 1'b0,
    CFG_MAX_GAP_US       = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0]  t;
    logic               valid;
    logic               down;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } ring_entry_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    ring_entry_t       entry;
  } ring_wr_t;

endpackage

// ===== rtl/core/tsfq_ring.sv =====
`timescale 1ns / 1ps
module tsfq_ring
  import tsfq_pkg::*;
(
  input  logic             clk,
  input  ring_wr_t         wr,
  input  logic [IDX_W-1:0] rd_addr,
  output ring_entry_t      rd_entry
);

  ring_entry_t mem [RING_DEPTH];
  ring_entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
  end

  // The read address is the next head, so the registered word always matches the
  // current head. A write to that same entry is forwarded.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.addr == rd_addr)) begin
      rd_entry_r <= wr.entry;
    end else begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

// ===== rtl/core/touch_sample_filter_queue.sv =====
`timescale 1ns / 1ps
// Touch sample filter and queue.
// The input channel carries push items (touch reports) and pop items, told apart by
// in_tuser. A push updates the tracked touch point and queues a sample when the touch
// state changes, or a cancel marker when the touch is cancelled. A pop returns the oldest
// queued sample, or present = 0 when the ring is empty. Only a pop produces an item on
// the output channel. Each item passes the input register, where the compare logic and
// the ring access run. A pop result then sits in the output register until it is taken.
// One item is taken per cycle unless a pop waits on a stalled receiver. That rate is set
// by the single ring write port.
// When the receiver stalls, a pending pop waits in the input register and blocks
// further input. Push items still pass while the output register is full.
// Synchronous active-low reset clears all tracking state, the fill level and the
// generation counter. It sets max_gap_us to 100000 and interrupt_driven to 0.
// Ring contents are not cleared; an entry is always written before it is read.
// Configuration must be written only while no item is in flight.
module touch_sample_filter_queue
  import tsfq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // touch_x[15:0], touch_y[31:16], touch_down[32], position_valid[33],
  // time_us[96:34], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd[0]
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_x[15:0], out_y[31:16], sample_down[32], sample_valid[33],
  // out_time[96:34], generation[128:97], zero fill above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // present[0]
  output logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SUM_W = CNT_W + 1;
  localparam int PAD_W = OUT_TDATA_W - (2 * COORD_W + 2 + TIME_W + GEN_W);

  // Configuration registers.
  logic             intr_driven_r;
  logic [GAP_W-1:0] max_gap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intr_driven_r <= 1'b0;
      max_gap_r     <= MAX_GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_INTERRUPT_DRIVEN: intr_driven_r <= cfg_wdata[0];
        CFG_MAX_GAP_US:       max_gap_r     <= cfg_wdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic               s1_valid_r;
  cmd_t               s1_cmd_r;
  logic [COORD_W-1:0] s1_x_r;
  logic [COORD_W-1:0] s1_y_r;
  logic               s1_down_r;
  logic               s1_pvalid_r;
  logic [TIME_W-1:0]  s1_time_r;
  logic               s1_fire;
  logic               in_fire;

  // Output register.
  logic                   out_valid_r;
  logic                   out_present_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // A push never needs the output register, a pop needs it free or draining.
  assign s1_fire   = s1_valid_r && ((s1_cmd_r == CMD_PUSH) || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r    <= cmd_t'(in_tuser);
      s1_x_r      <= in_tdata[15:0];
      s1_y_r      <= in_tdata[31:16];
      s1_down_r   <= in_tdata[32];
      s1_pvalid_r <= in_tdata[33];
      s1_time_r   <= in_tdata[96:34];
    end
  end

  // Tracking state.
  logic [COORD_W-1:0] last_x_r, last_x_nxt;
  logic [COORD_W-1:0] last_y_r, last_y_nxt;
  logic               last_down_r, last_down_nxt;
  logic [TIME_W-1:0]  last_time_r, last_time_nxt;
  logic               seen_any_r, seen_any_nxt;
  logic               blocked_r, blocked_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [GEN_W-1:0]   gen_r, gen_nxt;

  ring_wr_t    ring_wr;
  ring_entry_t ring_rd;

  tsfq_ring u_ring (
    .clk      (clk),
    .wr       (ring_wr),
    .rd_addr  (head_nxt),
    .rd_entry (ring_rd)
  );

  // Push decisions.
  logic [TIME_W-1:0]  time_diff;
  logic               backwards;
  logic               gap_exceeded;
  logic               time_cancel;
  logic [COORD_W-1:0] eff_x;
  logic [COORD_W-1:0] eff_y;
  logic               changed;
  logic               ring_full;
  logic [SUM_W-1:0]   tail_sum;
  logic [IDX_W-1:0]   tail_idx;
  logic [IDX_W-1:0]   head_inc;

  assign time_diff    = s1_time_r - last_time_r;
  assign backwards    = s1_time_r < last_time_r;
  assign gap_exceeded = !backwards && !intr_driven_r &&
                        (time_diff > TIME_W'(max_gap_r));
  assign time_cancel  = seen_any_r && (last_down_r || s1_down_r) &&
                        (backwards || gap_exceeded);

  // A release keeps the last measured position.
  assign eff_x   = s1_down_r ? s1_x_r : last_x_r;
  assign eff_y   = s1_down_r ? s1_y_r : last_y_r;
  assign changed = (last_down_r != s1_down_r) ||
                   (s1_down_r && ((s1_x_r != last_x_r) || (s1_y_r != last_y_r)));

  assign ring_full = (count_r == CNT_W'(RING_DEPTH));
  assign tail_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_idx  = (tail_sum >= SUM_W'(RING_DEPTH)) ?
                     IDX_W'(tail_sum - SUM_W'(RING_DEPTH)) : IDX_W'(tail_sum);
  assign head_inc  = (head_r == IDX_W'(RING_DEPTH - 1)) ? '0 : IDX_W'(head_r + 1'b1);

  always_comb begin
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    last_down_nxt = last_down_r;
    last_time_nxt = last_time_r;
    seen_any_nxt  = seen_any_r;
    blocked_nxt   = blocked_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    gen_nxt       = gen_r;
    ring_wr       = '0;

    if (s1_fire) begin
      case (s1_cmd_r)
        CMD_POP: begin
          if (count_r != '0) begin
            head_nxt  = head_inc;
            count_nxt = CNT_W'(count_r - 1'b1);
          end
        end
        CMD_PUSH: begin
          // Cancel marker fields; the position is overridden for a full ring.
          ring_wr.entry.t     = s1_time_r;
          ring_wr.entry.valid = 1'b0;
          ring_wr.entry.down  = 1'b0;
          ring_wr.entry.x     = last_x_r;
          ring_wr.entry.y     = last_y_r;

          if (!s1_pvalid_r) begin
            // Invalid report: cancel unless already blocked, keep the position.
            if (!blocked_r) begin
              ring_wr.en = 1'b1;
            end
            last_time_nxt = s1_time_r;
            seen_any_nxt  = 1'b1;
          end else if (blocked_r) begin
            // Track only; a release lifts the block.
            if (!s1_down_r) begin
              blocked_nxt = 1'b0;
            end
            last_x_nxt    = s1_x_r;
            last_y_nxt    = s1_y_r;
            last_down_nxt = s1_down_r;
            last_time_nxt = s1_time_r;
            seen_any_nxt  = 1'b1;
          end else if (time_cancel) begin
            ring_wr.en    = 1'b1;
            last_x_nxt    = s1_x_r;
            last_y_nxt    = s1_y_r;
            last_down_nxt = s1_down_r;
            last_time_nxt = s1_time_r;
          end else begin
            last_x_nxt    = eff_x;
            last_y_nxt    = eff_y;
            last_down_nxt = s1_down_r;
            last_time_nxt = s1_time_r;
            seen_any_nxt  = 1'b1;
            if (changed) begin
              if (ring_full) begin
                ring_wr.en      = 1'b1;
                ring_wr.entry.x = eff_x;
                ring_wr.entry.y = eff_y;
              end else begin
                ring_wr.en          = 1'b1;
                ring_wr.addr        = tail_idx;
                ring_wr.entry.valid = 1'b1;
                ring_wr.entry.down  = s1_down_r;
                ring_wr.entry.x     = eff_x;
                ring_wr.entry.y     = eff_y;
                count_nxt           = CNT_W'(count_r + 1'b1);
              end
            end
          end

          // A marker write (an entry with valid clear) is a cancel: restart the ring with the
          // marker alone at entry zero and block queueing.
          if (ring_wr.en && !ring_wr.entry.valid) begin
            ring_wr.addr = '0;
            gen_nxt      = GEN_W'(gen_r + 1'b1);
            head_nxt     = '0;
            count_nxt    = CNT_W'(1);
            blocked_nxt  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_down_r <= 1'b0;
      last_time_r <= '0;
      seen_any_r  <= 1'b0;
      blocked_r   <= 1'b0;
      head_r      <= '0;
      count_r     <= '0;
      gen_r       <= '0;
    end else begin
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      last_down_r <= last_down_nxt;
      last_time_r <= last_time_nxt;
      seen_any_r  <= seen_any_nxt;
      blocked_r   <= blocked_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      gen_r       <= gen_nxt;
    end
  end

  // Pop result; an empty ring reports only the generation.
  logic                   pop_fire;
  logic                   pop_present;
  logic [OUT_TDATA_W-1:0] pop_data;

  assign pop_fire    = s1_fire && (s1_cmd_r == CMD_POP);
  assign pop_present = (count_r != '0);
  assign pop_data    = pop_present ?
                       {PAD_W'(0), gen_r, ring_rd.t, ring_rd.valid, ring_rd.down,
                        ring_rd.y, ring_rd.x} :
                       {PAD_W'(0), gen_r, (OUT_TDATA_W - PAD_W - GEN_W)'(0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_fire) begin
      out_present_r <= pop_present;
      out_data_r    <= pop_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_present_r;

endmodule

// ===== rtl/core/tsfq_checker.sv =====
`timescale 1ns / 1ps
`include "touch_sample_filter_queue_defines.svh"
module tsfq_checker
  import tsfq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // A stalled result keeps its contents.
  `TSFQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // An empty pop carries only the generation.
  `TSFQ_ASSERT_NOW(a_empty_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata[96:0] == '0, "empty pop has nonzero sample fields")

  // A cancel marker is always a released sample.
  `TSFQ_ASSERT_NOW(a_marker_released, clk, rst_n, out_tvalid && out_tuser && !out_tdata[33], !out_tdata[32], "cancel marker reported as pressed")

endmodule

bind touch_sample_filter_queue tsfq_checker u_tsfq_checker (.*);
